// File: rtl/iepf_pkg.sv
// Shared types and constants for the ICMP echo parity packet filter.
`timescale 1ns / 1ps
package iepf_pkg;

  typedef logic [6:0] count_t;
  typedef logic [3:0] ihl_t;
  typedef logic [1:0] cause_t;

  localparam cause_t CAUSE_NONE      = 2'd0;
  localparam cause_t CAUSE_SHORT_ETH = 2'd1;
  localparam cause_t CAUSE_BAD_IPV4  = 2'd2;
  localparam cause_t CAUSE_EVEN_ECHO = 2'd3;

  localparam count_t ETH_HDR_LEN   = 7'd14;
  localparam count_t ETYPE_HI_POS  = 7'd12;
  localparam count_t ETYPE_LO_POS  = 7'd13;
  localparam count_t IHL_POS       = 7'd14;
  localparam count_t PROTO_POS     = 7'd23;
  localparam count_t IP_MIN_END    = 7'd34;
  localparam count_t ICMP_HDR_LEN  = 7'd8;
  localparam count_t ICMP_SEQ_OFS  = 7'd7;
  localparam count_t COUNT_MAX     = 7'd127;
  localparam ihl_t   IP_MIN_IHL    = 4'd5;

  localparam logic [7:0] ETYPE_HI_IPV4 = 8'h08;
  localparam logic [7:0] ETYPE_LO_IPV4 = 8'h00;
  localparam logic [7:0] PROTO_ICMP    = 8'h01;
  localparam logic [7:0] ECHO_REQUEST  = 8'h08;

endpackage

// File: rtl/iepf_in_if.sv
// Byte stream channel carrying frame bytes into the filter.
`timescale 1ns / 1ps
interface iepf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_byte;

  modport source (output valid, output packet_byte, output last_byte, input ready);
  modport sink (input valid, input packet_byte, input last_byte, output ready);
endinterface

// File: rtl/iepf_out_if.sv
// Verdict channel carrying one pass/drop request per frame.
`timescale 1ns / 1ps
interface iepf_out_if;
  import iepf_pkg::*;

  logic   valid;
  logic   ready;
  logic   drop;
  cause_t drop_cause;

  modport source (output valid, output drop, output drop_cause, input ready);
  modport sink (input valid, input drop, input drop_cause, output ready);
endinterface

// File: rtl/icmp_echo_parity_packet_filter_top.sv
// Top level: streaming Ethernet/IPv4/ICMP echo parity filter.
// The verdict is registered on the last byte, into the skid entry if the output is held.
// Throughput: one byte per cycle; a two-entry output buffer keeps bytes flowing while
// a verdict waits to be taken, and input stalls only when both entries are full.
// Reset (synchronous, rst_n low): frame state cleared, output buffer emptied.
`timescale 1ns / 1ps
module icmp_echo_parity_packet_filter_top (
  input logic        clk,
  input logic        rst_n,
  iepf_in_if.sink    in_s,
  iepf_out_if.source out_m
);
  import iepf_pkg::*;

  // frame state
  count_t byte_count_r, byte_count_nxt;
  logic   eth_hi_ok_r, eth_hi_ok_nxt;
  logic   is_ipv4_r, is_ipv4_nxt;
  ihl_t   hdr_words_r, hdr_words_nxt;
  logic   is_icmp_r, is_icmp_nxt;
  logic   is_echo_r, is_echo_nxt;
  logic   seq_odd_r, seq_odd_nxt;

  // output buffer
  logic   out_valid_r, skid_valid_r;
  logic   out_drop_r, skid_drop_r;
  cause_t out_cause_r, skid_cause_r;

  logic   in_fire, push, pop;
  count_t pos, base, ip_end_nxt;
  logic   res_drop;
  cause_t res_cause;

  assign in_s.ready       = !skid_valid_r;
  assign in_fire          = in_s.valid && in_s.ready;
  assign push             = in_fire && in_s.last_byte;
  assign pop              = out_valid_r && out_m.ready;
  assign out_m.valid      = out_valid_r;
  assign out_m.drop       = out_drop_r;
  assign out_m.drop_cause = out_cause_r;

  assign pos  = byte_count_r;
  assign base = ETH_HDR_LEN + {1'b0, hdr_words_r, 2'b00};

  always_comb begin
    eth_hi_ok_nxt = eth_hi_ok_r;
    is_ipv4_nxt   = is_ipv4_r;
    hdr_words_nxt = hdr_words_r;
    is_icmp_nxt   = is_icmp_r;
    is_echo_nxt   = is_echo_r;
    seq_odd_nxt   = seq_odd_r;

    if (pos == ETYPE_HI_POS) begin
      eth_hi_ok_nxt = (in_s.packet_byte == ETYPE_HI_IPV4);
    end else if (pos == ETYPE_LO_POS) begin
      is_ipv4_nxt = eth_hi_ok_r && (in_s.packet_byte == ETYPE_LO_IPV4);
    end else if (pos == IHL_POS) begin
      hdr_words_nxt = in_s.packet_byte[3:0];
    end else if (pos == PROTO_POS) begin
      is_icmp_nxt = (in_s.packet_byte == PROTO_ICMP);
    end

    // ICMP bytes use the header length captured on an earlier byte
    if (pos > IHL_POS && hdr_words_r >= IP_MIN_IHL) begin
      if (pos == base) begin
        is_echo_nxt = (in_s.packet_byte == ECHO_REQUEST);
      end else if (pos == base + ICMP_SEQ_OFS) begin
        seq_odd_nxt = in_s.packet_byte[0];
      end
    end

    byte_count_nxt = (pos == COUNT_MAX) ? COUNT_MAX : pos + 7'd1;
  end

  // verdict from the state including the current byte
  assign ip_end_nxt = ETH_HDR_LEN + {1'b0, hdr_words_nxt, 2'b00};

  always_comb begin
    res_drop  = 1'b0;
    res_cause = CAUSE_NONE;
    if (byte_count_nxt < ETH_HDR_LEN) begin
      res_drop  = 1'b1;
      res_cause = CAUSE_SHORT_ETH;
    end else if (is_ipv4_nxt) begin
      if (byte_count_nxt < IP_MIN_END || hdr_words_nxt < IP_MIN_IHL ||
          ip_end_nxt > byte_count_nxt) begin
        res_drop  = 1'b1;
        res_cause = CAUSE_BAD_IPV4;
      end else if (is_icmp_nxt && (ip_end_nxt + ICMP_HDR_LEN <= byte_count_nxt) &&
                   is_echo_nxt && !seq_odd_nxt) begin
        res_drop  = 1'b1;
        res_cause = CAUSE_EVEN_ECHO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      eth_hi_ok_r  <= 1'b0;
      is_ipv4_r    <= 1'b0;
      hdr_words_r  <= '0;
      is_icmp_r    <= 1'b0;
      is_echo_r    <= 1'b0;
      seq_odd_r    <= 1'b0;
    end else if (in_fire) begin
      if (in_s.last_byte) begin
        // drop all frame state after the verdict
        byte_count_r <= '0;
        eth_hi_ok_r  <= 1'b0;
        is_ipv4_r    <= 1'b0;
        hdr_words_r  <= '0;
        is_icmp_r    <= 1'b0;
        is_echo_r    <= 1'b0;
        seq_odd_r    <= 1'b0;
      end else begin
        byte_count_r <= byte_count_nxt;
        eth_hi_ok_r  <= eth_hi_ok_nxt;
        is_ipv4_r    <= is_ipv4_nxt;
        hdr_words_r  <= hdr_words_nxt;
        is_icmp_r    <= is_icmp_nxt;
        is_echo_r    <= is_echo_nxt;
        seq_odd_r    <= seq_odd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_drop_r  <= skid_drop_r;
        out_cause_r <= skid_cause_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_drop_r  <= res_drop;
        out_cause_r <= res_cause;
      end else begin
        // hold the new request until the output register frees
        skid_drop_r  <= res_drop;
        skid_cause_r <= res_cause;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_cause_matches_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_drop_r == (out_cause_r != CAUSE_NONE)))
    else $error("drop flag disagrees with drop cause");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (byte_count_r == '0 && !is_ipv4_r && !is_echo_r))
    else $error("frame state not cleared after last byte");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid_r)
    else $error("verdict lost after last byte");

endmodule
